// File: rtl/core/voice_prompt_serial_sender_defines.svh
// Assertion macros for the voice prompt serial sender.
`ifndef VOICE_PROMPT_SERIAL_SENDER_DEFINES_SVH
`define VOICE_PROMPT_SERIAL_SENDER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define VPSS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define VPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/vpss_pkg.sv
// Types and constants shared by the voice prompt serial sender.
package vpss_pkg;

    typedef struct packed {
        logic        opcode;
        logic [15:0] prompt;
        logic        busy_req;
    } t_in_item;

    typedef struct packed {
        logic clk_out;
        logic data_out;
        logic reset_out;
        logic playing;
        logic push_dropped;
        logic ready_res;
    } t_out_item;

    // queue control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    // queue status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // input item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    // register indexes, byte address is four times the index
    localparam logic [1:0] REG_MUTE        = 2'd0;
    localparam logic [1:0] REG_START_TICKS = 2'd1;
    localparam logic [1:0] REG_STOP_TICKS  = 2'd2;
    localparam logic [1:0] REG_RESET_TICKS = 2'd3;

    localparam logic [2:0] PH_RESET     = 3'd0;
    localparam logic [2:0] PH_RESETWAIT = 3'd1;
    localparam logic [2:0] PH_PAUSE     = 3'd2;
    localparam logic [2:0] PH_START     = 3'd3;
    localparam logic [2:0] PH_DATA      = 3'd4;
    localparam logic [2:0] PH_STOP      = 3'd5;

    localparam logic       RST_MUTE        = 1'b0;
    localparam logic [7:0] RST_START_TICKS = 8'd5;
    localparam logic [7:0] RST_STOP_TICKS  = 8'd84;
    localparam logic [7:0] RST_RESET_TICKS = 8'd4;

endpackage

// File: rtl/core/vpss_queue.sv
// Prompt ring queue with a prefetched head word.
module vpss_queue
    import vpss_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_q_ctl                     i_ctl,
    input  logic [WIDTH-1:0]           i_wr_data,
    output logic [WIDTH-1:0]           o_head,
    output t_q_stat                    o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [WIDTH-1:0] r_head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_ctl.push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_ctl.pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // head tracks the next read pointer; bypass a write into that slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (i_ctl.push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_wr_data;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_head     = r_head;
    assign o_count    = r_count;
    assign o_stat     = '{empty: (r_count == '0), full: (r_count == CNT_W'(DEPTH))};

endmodule

// File: rtl/core/voice_prompt_serial_sender.sv
// Top level of the voice prompt serial sender: sequencer, registers, output skid.
// Each accepted input transfer yields one result, registered in the result register or the skid.
// Throughput: one item per cycle while the skid is empty; the sequencer updates all state in the accept cycle.
// A two-deep output buffer (result register plus skid) keeps input open while a result waits.
// Reset (i_rst_n low, synchronous) restores registers to defaults, empties the queue
// and starts the module-reset phase; queue entries themselves are not cleared.
`include "voice_prompt_serial_sender_defines.svh"

module voice_prompt_serial_sender
    import vpss_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORD_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int BITS_W = $clog2(WORD_BITS + 1);

    // configuration registers
    logic       r_mute;
    logic [7:0] r_start_ticks;
    logic [7:0] r_stop_ticks;
    logic [7:0] r_reset_ticks;

    // sequencer state
    logic [2:0]           r_phase,   n_phase;
    logic [7:0]           r_tick,    n_tick;
    logic [WORD_BITS-1:0] r_shift,   n_shift;
    logic [BITS_W-1:0]    r_bits,    n_bits;
    logic                 r_clk,     n_clk;
    logic                 r_data,    n_data;
    logic                 r_rstl,    n_rstl;
    logic                 r_running, n_running;
    logic                 dropped;

    // output buffer
    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;
    t_out_item res;

    // queue
    t_q_ctl               q_ctl;
    t_q_stat              q_stat;
    logic [WORD_BITS-1:0] q_head;
    logic [CNT_W-1:0]     q_count;

    logic in_accept;
    logic out_take;
    logic cfg_wr;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_out_stall;
    assign cfg_wr    = psel && penable && pwrite;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;

    vpss_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (q_ctl),
        .i_wr_data (WORD_BITS'(i_in_data.prompt)),
        .o_head    (q_head),
        .o_stat    (q_stat),
        .o_count   (q_count)
    );

    // ------------------------------------------------------------------
    // Configuration registers and read-back
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute        <= RST_MUTE;
            r_start_ticks <= RST_START_TICKS;
            r_stop_ticks  <= RST_STOP_TICKS;
            r_reset_ticks <= RST_RESET_TICKS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MUTE:        r_mute        <= pwdata[0];
                REG_START_TICKS: r_start_ticks <= pwdata[7:0];
                REG_STOP_TICKS:  r_stop_ticks  <= pwdata[7:0];
                REG_RESET_TICKS: r_reset_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MUTE:        prdata = {31'd0, r_mute};
            REG_START_TICKS: prdata = {24'd0, r_start_ticks};
            REG_STOP_TICKS:  prdata = {24'd0, r_stop_ticks};
            REG_RESET_TICKS: prdata = {24'd0, r_reset_ticks};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: one accepted transfer is either a push or a tick.
    // ------------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_shift   = r_shift;
        n_bits    = r_bits;
        n_clk     = r_clk;
        n_data    = r_data;
        n_rstl    = r_rstl;
        n_running = r_running;
        q_ctl     = '0;
        dropped   = 1'b0;

        if (in_accept) begin
            if (i_in_data.opcode == OP_PUSH) begin
                // push: muted pushes leave everything alone
                if (!r_mute) begin
                    if (q_stat.full) begin
                        dropped = 1'b1;
                    end else begin
                        q_ctl.push = 1'b1;
                    end
                    n_running = 1'b1;
                end
            end else if (r_running) begin
                // unused phase codes fall back to the pause
                if (r_phase > PH_STOP) begin
                    n_phase = PH_PAUSE;
                end
                // pause: fetch the next prompt, or go idle on an empty queue
                if (n_phase == PH_PAUSE) begin
                    if (q_stat.empty) begin
                        n_running = 1'b0;
                    end else begin
                        n_shift    = q_head;
                        q_ctl.pop  = 1'b1;
                        n_tick     = r_start_ticks;
                        n_phase    = PH_START;
                    end
                end
                case (n_phase)
                    PH_PAUSE: ;
                    PH_START: begin
                        n_clk = 1'b0;
                        if (n_tick != 8'd0) begin
                            n_tick = n_tick - 8'd1;
                        end
                        if (n_tick == 8'd0) begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        // data set with clock low, then clock rises
                        if (!n_clk) begin
                            if (n_shift[WORD_BITS-1]) begin
                                n_data = 1'b1;
                            end
                            n_shift = n_shift << 1;
                            n_bits  = n_bits + BITS_W'(1);
                            n_clk   = 1'b1;
                        end else begin
                            n_clk  = 1'b0;
                            n_data = 1'b0;
                        end
                        if (n_bits >= BITS_W'(WORD_BITS)) begin
                            n_bits  = '0;
                            n_tick  = r_stop_ticks;
                            n_phase = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        // clock held high until the count runs out and busy drops
                        n_data = 1'b0;
                        n_clk  = 1'b1;
                        if (n_tick != 8'd0) begin
                            n_tick = n_tick - 8'd1;
                        end
                        if ((n_tick == 8'd0) && !i_in_data.busy_req) begin
                            n_phase = PH_PAUSE;
                        end
                    end
                    PH_RESET: begin
                        if (n_tick != 8'd0) begin
                            n_rstl = 1'b0;
                            n_data = 1'b0;
                            n_clk  = 1'b1;
                            n_tick = n_tick - 8'd1;
                        end else begin
                            n_phase = PH_RESETWAIT;
                        end
                    end
                    default: begin
                        // reset release, wait for the module to come out of busy
                        n_rstl = 1'b1;
                        if (!i_in_data.busy_req) begin
                            n_phase = PH_PAUSE;
                        end
                    end
                endcase
            end
        end

        // a new reset length reloads the counter while still in the reset phase
        if (cfg_wr && (paddr[3:2] == REG_RESET_TICKS) && (r_phase == PH_RESET)) begin
            n_tick = pwdata[7:0];
        end

        res = '{
            clk_out:      n_clk,
            data_out:     n_data,
            reset_out:    n_rstl,
            playing:      n_running,
            push_dropped: dropped,
            ready_res:    (n_phase == PH_PAUSE)
        };
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RESET;
            r_tick    <= RST_RESET_TICKS;
            r_shift   <= '0;
            r_bits    <= '0;
            r_clk     <= 1'b0;
            r_data    <= 1'b0;
            r_rstl    <= 1'b1;
            r_running <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_shift   <= n_shift;
            r_bits    <= n_bits;
            r_clk     <= n_clk;
            r_data    <= n_data;
            r_rstl    <= n_rstl;
            r_running <= n_running;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: result register plus one skid entry.
    // The skid fills only while the result register is held by a stall,
    // and input stalls only while the skid is full.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= res;
            end
        end else if (in_accept) begin
            r_skid <= res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // reset pin may only be low in the reset and reset-wait phases (codes 0 and 1)
    `VPSS_ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full, result empty")
    `VPSS_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue overfull")
    `VPSS_ASSERT_IMPL(a_reset_pin, !r_rstl, r_phase <= PH_RESETWAIT, "reset pin low late")
    `VPSS_ASSERT_NEXT(a_skid_fill, r_out_valid && i_out_stall && in_accept, r_skid_valid, "skid missed")

endmodule

// File: verif/tb_voice_prompt_serial_sender.sv
// Self-checking testbench for the voice prompt serial sender: random traffic, APB setup, scoreboard.
module tb_voice_prompt_serial_sender;
    timeunit 1ns;
    timeprecision 1ps;
    import vpss_pkg::*;

    localparam int Q_DEPTH     = 16;
    localparam int QUIET_LIMIT = 1000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 80;    // one long receiver hold-off
    localparam int HOLD_AT     = 120;   // results seen before the hold-off starts
    localparam int CALM_LO     = 700;   // window with no idling on either side
    localparam int CALM_HI     = 900;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_vld    = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    always #5 i_clk = ~i_clk;

    voice_prompt_serial_sender u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // predictor state: a private copy of the sender, starting at reset values
    // ------------------------------------------------------------------
    logic [2:0]  ph        = PH_RESET;
    logic [7:0]  tick_cnt  = RST_RESET_TICKS;
    logic [15:0] shreg     = '0;
    logic [4:0]  nbits     = '0;
    logic        clk_lv    = 1'b0;
    logic        dat_lv    = 1'b0;
    logic        rst_lv    = 1'b1;
    logic        run       = 1'b1;
    logic [15:0] pq [Q_DEPTH];
    logic [3:0]  wp        = '0;   // 4-bit pointers wrap at the queue depth
    logic [3:0]  rp        = '0;
    logic [4:0]  qcnt      = '0;
    logic        cfg_mute  = RST_MUTE;
    logic [7:0]  cfg_start = RST_START_TICKS;
    logic [7:0]  cfg_stop  = RST_STOP_TICKS;
    logic [7:0]  cfg_reset = RST_RESET_TICKS;

    t_in_item    items_to_send [$];  // stimulus not yet offered
    t_out_item   levels_due [$];     // predicted pin levels, oldest first

    logic        in_fire = 1'b0;     // input transfer at the last rising edge
    int          errors    = 0;
    int          n_accepted = 0;
    int          n_checked  = 0;
    int          n_ticks    = 0;
    int          n_pushes   = 0;
    int          n_dropped  = 0;
    int          n_cfg      = 0;
    int          hold_left  = 0;
    bit          held_once  = 1'b0;
    int          quiet      = 0;

    string field_name [6] = '{"ready_res", "push_dropped", "playing",
                              "reset_out", "data_out", "clk_out"};

    // ------------------------------------------------------------------
    // predictor: applies one accepted item, returns the pin levels after it
    // ------------------------------------------------------------------
    function automatic t_out_item step_sender(input t_in_item it);
        t_out_item lv;
        logic      dropped;
        logic      acting;
        dropped = 1'b0;
        acting  = run;
        if (it.opcode == OP_PUSH) begin
            // muted push changes nothing; a push into a full queue is lost
            if (!cfg_mute) begin
                if (qcnt >= 5'(Q_DEPTH)) begin
                    dropped = 1'b1;
                    n_dropped++;
                end else begin
                    pq[wp] = it.prompt;
                    wp++;
                    qcnt++;
                end
                run = 1'b1;
            end
        end else if (acting) begin
            if (ph > PH_STOP) ph = PH_PAUSE;
            // pause: either go to sleep on an empty queue or load the next word
            if (ph == PH_PAUSE) begin
                if (qcnt == 0) begin
                    run    = 1'b0;
                    acting = 1'b0;
                end else begin
                    shreg    = pq[rp];
                    rp++;
                    qcnt--;
                    tick_cnt = cfg_start;
                    ph       = PH_START;
                end
            end
            if (acting) begin
                case (ph)
                    PH_START: begin
                        clk_lv = 1'b0;
                        if (tick_cnt > 0) tick_cnt--;
                        if (tick_cnt == 0) ph = PH_DATA;
                    end
                    PH_DATA: begin
                        // low half sets data and raises clock, high half drops both
                        if (!clk_lv) begin
                            if (shreg[15]) dat_lv = 1'b1;
                            shreg  = shreg << 1;
                            nbits++;
                            clk_lv = 1'b1;
                        end else begin
                            clk_lv = 1'b0;
                            dat_lv = 1'b0;
                        end
                        if (nbits >= 5'd16) begin
                            nbits    = '0;
                            tick_cnt = cfg_stop;
                            ph       = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        dat_lv = 1'b0;
                        clk_lv = 1'b1;
                        if (tick_cnt > 0) tick_cnt--;
                        if (tick_cnt == 0 && !it.busy_req) ph = PH_PAUSE;
                    end
                    PH_RESET: begin
                        if (tick_cnt > 0) begin
                            rst_lv = 1'b0;
                            dat_lv = 1'b0;
                            clk_lv = 1'b1;
                            tick_cnt--;
                        end else begin
                            ph = PH_RESETWAIT;
                        end
                    end
                    default: begin
                        // reset released, wait for the module to drop busy
                        rst_lv = 1'b1;
                        if (!it.busy_req) ph = PH_PAUSE;
                    end
                endcase
            end
        end
        lv.clk_out      = clk_lv;
        lv.data_out     = dat_lv;
        lv.reset_out    = rst_lv;
        lv.playing      = run;
        lv.push_dropped = dropped;
        lv.ready_res    = (ph == PH_PAUSE);
        return lv;
    endfunction

    task automatic report_mismatch(input string what, input logic [5:0] got,
                                   input logic [5:0] want);
        errors++;
        $display("[%0t] mismatch: %s (got %b, expected %b)", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items at the falling edge, holds until transfer
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_in
        logic calm;
        calm = (n_accepted >= CALM_LO) && (n_accepted < CALM_HI);
        if (rst_n && (!in_vld || in_fire)) begin
            if (items_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
                in_item <= items_to_send.pop_front();
                in_vld  <= 1'b1;
            end else begin
                in_vld  <= 1'b0;
            end
        end
    end

    // receiver side: random stalls, one long hold-off so the block backs up
    always @(negedge i_clk) begin : drive_stall
        logic calm;
        calm = (n_checked >= CALM_LO) && (n_checked < CALM_HI);
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!held_once && n_checked >= HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < 22);
        end
    end

    // ------------------------------------------------------------------
    // monitor: check the result transfer first, then predict the new input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        in_fire = rst_n && in_vld && !o_in_stall;
        if (rst_n && o_out_valid && !out_stall) begin
            n_checked++;
            if (levels_due.size() == 0) begin
                report_mismatch("result with nothing expected", o_out_data, '0);
            end else begin
                want = levels_due.pop_front();
                for (int b = 5; b >= 0; b--) begin
                    if (o_out_data[b] !== want[b])
                        report_mismatch(field_name[b], o_out_data, want);
                end
            end
        end
        if (in_fire) begin
            n_accepted++;
            if (in_item.opcode == OP_PUSH) n_pushes++;
            else n_ticks++;
            levels_due.push_back(step_sender(in_item));
        end
    end

    // watchdog: any transfer or register access restarts the count
    always @(posedge i_clk) begin : watchdog
        if ((rst_n && in_vld && !o_in_stall) || (rst_n && o_out_valid && !out_stall) || psel)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAIL voice_prompt_serial_sender");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic op, input logic [15:0] word, input logic busy);
        t_in_item it;
        it.opcode   = op;
        it.prompt   = word;
        it.busy_req = busy;
        items_to_send.push_back(it);
    endtask

    // register write: setup cycle, then access cycle; predictor follows at the write edge
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MUTE:        cfg_mute  = value[0];
            REG_START_TICKS: cfg_start = value;
            REG_STOP_TICKS:  cfg_stop  = value;
            REG_RESET_TICKS: begin
                cfg_reset = value;
                if (ph == PH_RESET) tick_cnt = value;  // reload while still in reset
            end
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every offered item is through and its result has come back
    task automatic drain();
        while (items_to_send.size() != 0 || in_vld || levels_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // bursts of pushes (now and then enough to overrun the queue), then runs of ticks
    task automatic queue_traffic(input int count);
        int added;
        int burst;
        added = 0;
        while (added < count) begin
            burst = ($urandom_range(0, 99) < 8) ? $urandom_range(15, 20)
                                                : $urandom_range(0, 2);
            repeat (burst) begin
                add_item(OP_PUSH, 16'($urandom), 1'($urandom_range(0, 1)));
                added++;
            end
            burst = $urandom_range(10, 60);
            repeat (burst) begin
                add_item(OP_TICK, 16'($urandom), $urandom_range(0, 99) < 15);
                added++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < Q_DEPTH; i++) pq[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        // setting 1: reset length reloaded while still in reset, zero start/stop counts
        write_reg(REG_RESET_TICKS, 8'd3);
        write_reg(REG_START_TICKS, 8'd0);
        write_reg(REG_STOP_TICKS, 8'd0);
        write_reg(REG_MUTE, 8'd0);

        // reset pulse, busy wait, then sleep on an empty queue
        add_item(OP_TICK, 16'hFFFF, 1'b1);
        add_item(OP_TICK, 16'h0000, 1'b1);
        add_item(OP_TICK, 16'h0000, 1'b0);
        add_item(OP_TICK, 16'h0000, 1'b0);   // reset count spent, go to reset wait
        add_item(OP_TICK, 16'h0000, 1'b1);   // release reset, module still busy
        add_item(OP_TICK, 16'h0000, 1'b0);   // busy gone, enter pause
        add_item(OP_TICK, 16'h0000, 1'b0);   // nothing queued, stop running
        add_item(OP_TICK, 16'hFFFF, 1'b1);   // ignored while stopped
        // fill the queue, then one more push that must be dropped
        add_item(OP_PUSH, 16'hFFFF, 1'b0);
        add_item(OP_PUSH, 16'h0000, 1'b1);
        add_item(OP_PUSH, 16'h8000, 1'b0);
        add_item(OP_PUSH, 16'h0001, 1'b1);
        repeat (12) add_item(OP_PUSH, 16'($urandom), 1'($urandom_range(0, 1)));
        add_item(OP_PUSH, 16'hA5A5, 1'b0);
        add_item(OP_TICK, 16'h0000, 1'b0);
        queue_traffic(250);
        drain();

        // setting 2: muted, start and stop counts of one, zero reset length
        write_reg(REG_MUTE, 8'd1);
        write_reg(REG_START_TICKS, 8'd1);
        write_reg(REG_STOP_TICKS, 8'd1);
        write_reg(REG_RESET_TICKS, 8'd0);
        add_item(OP_PUSH, 16'h1234, 1'b0);
        queue_traffic(120);
        drain();

        // setting 3: longest start and stop bits
        write_reg(REG_MUTE, 8'd0);
        write_reg(REG_START_TICKS, 8'd255);
        write_reg(REG_STOP_TICKS, 8'd255);
        write_reg(REG_RESET_TICKS, 8'd255);
        queue_traffic(450);
        drain();

        // setting 4: short random counts, most prompts complete
        write_reg(REG_START_TICKS, 8'($urandom_range(1, 16)));
        write_reg(REG_STOP_TICKS, 8'($urandom_range(1, 40)));
        write_reg(REG_RESET_TICKS, RST_RESET_TICKS);
        queue_traffic(350);
        drain();

        repeat (5) @(posedge i_clk);
        $display("covered %0d ticks and %0d pushes (%0d dropped on a full queue), %0d register writes",
                 n_ticks, n_pushes, n_dropped, n_cfg);
        $display("checked %0d results, %0d mismatches", n_checked, errors);
        if (errors == 0) begin
            $display("PASS voice_prompt_serial_sender");
        end else begin
            $display("FAIL voice_prompt_serial_sender");
        end
        $finish;
    end

endmodule
